@@ rtl/core/gyro_bias_noise_calibration_defines.svh @@
// Assertion helpers used by the calibration top level.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef GYRO_BIAS_NOISE_CALIBRATION_DEFINES_SVH
`define GYRO_BIAS_NOISE_CALIBRATION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBNC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GBNC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/gbnc_pkg.sv @@
package gbnc_pkg;

	// A run ends on this sample at the latest.
	localparam int MAX_SAMPLES = 255;
	// Width of one raw gyro sample.
	localparam int SAMPLE_BITS = 16;

	localparam int AXES   = 3;
	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	// Signed per-axis sum of samples.
	localparam int SUM_W  = SAMPLE_BITS + CNT_W + 1;
	// Square of one sample magnitude (at most 2^(2*SAMPLE_BITS-2)).
	localparam int SQR_W  = 2 * SAMPLE_BITS - 1;
	// Per-axis sum of squares; also the dividend width of the divider.
	localparam int SQ_W   = SQR_W + CNT_W;
	// Step counter covers the longer of the two iterative units.
	localparam int STEP_W = $clog2(SQ_W);

	// Per-cycle commands from the sequencer to each axis lane.
	typedef struct packed {
		logic take;       // An input sample transfer happens this cycle.
		logic acc;        // Stage 1 holds a sample to accumulate.
		logic fin;        // The sample in stage 1 ends the run.
		logic div_step;   // One quotient bit per cycle.
		logic mul;        // Square the mean magnitude.
		logic root_load;  // Form the variance and start the square root.
		logic root_step;  // One root bit per cycle.
	} lane_ctrl_t;

endpackage

@@ rtl/core/gbnc_div.sv @@
// Restoring divider by the sample count, one quotient bit per cycle while step is high.
// After SQ_W steps the dividend register holds the quotient.
module gbnc_div import gbnc_pkg::*; (
	input  logic             clk,
	input  logic             load,
	input  logic             step,
	input  logic [SQ_W-1:0]  dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic [SQ_W-1:0]  quotient
);

	logic [SQ_W-1:0]  dvd_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W:0]   shifted;
	logic             fits;
	logic [CNT_W:0]   diff;

	// Bring down the next dividend bit and try a subtraction.
	assign shifted = {rem_q, dvd_q[SQ_W-1]};
	assign fits    = shifted >= {1'b0, divisor};
	assign diff    = shifted - {1'b0, divisor};

	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (step) begin
			dvd_q <= {dvd_q[SQ_W-2:0], fits};
			rem_q <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
		end
	end

	assign quotient = dvd_q;

endmodule

@@ rtl/core/gbnc_isqrt.sv @@
// Digit-by-digit integer square root, one result bit per cycle while step is high.
// SAMPLE_BITS steps after a load, root holds floor(sqrt(radicand)).
module gbnc_isqrt import gbnc_pkg::*; (
	input  logic                   clk,
	input  logic                   load,
	input  logic                   step,
	input  logic [SQR_W-1:0]       radicand,
	output logic [SAMPLE_BITS-1:0] root
);

	logic [SQR_W-1:0] v_q;
	logic [SQR_W:0]   r_q;
	logic [SQR_W:0]   bit_q;
	logic [SQR_W:0]   trial;
	logic             fits;

	assign trial = r_q + bit_q;
	assign fits  = {1'b0, v_q} >= trial;

	always_ff @(posedge clk) begin
		if (load) begin
			v_q   <= radicand;
			r_q   <= '0;
			// Start at the highest power of four that the radicand can reach.
			bit_q <= {1'b0, 1'b1, {(SQR_W-1){1'b0}}};
		end else if (step) begin
			// Accept the trial bit when the remainder covers it.
			if (fits) begin
				v_q <= v_q - trial[SQR_W-1:0];
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = r_q[SAMPLE_BITS-1:0];

endmodule

@@ rtl/core/gbnc_lane.sv @@
// One axis: squares and accumulates samples, then divides both sums by the
// count, squares the mean and takes the root of the clamped variance.
module gbnc_lane import gbnc_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lane_ctrl_t                    ctrl,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic [CNT_W-1:0]              count,
	output logic signed [SAMPLE_BITS-1:0] bias,
	output logic [SAMPLE_BITS-1:0]        noise
);

	logic signed [SAMPLE_BITS-1:0] smp_s1;
	logic [SQR_W-1:0]              sq_s1;
	logic signed [SUM_W-1:0]       sum_q;
	logic [SQ_W-1:0]               sqs_q;
	logic                          neg_q;
	logic [SQR_W-1:0]              msq_q;
	logic [SQR_W-1:0]              mean_sq_q;

	logic [SAMPLE_BITS-1:0]        mag_in;
	logic [2*SAMPLE_BITS-1:0]      sq_full;
	logic signed [SUM_W-1:0]       sum_nxt;
	logic [SQ_W-1:0]               sqs_nxt;
	logic [SUM_W-1:0]              sum_mag;
	logic                          div_load;
	logic [SQ_W-1:0]               q_sum;
	logic [SQ_W-1:0]               q_sqs;
	logic [SAMPLE_BITS-1:0]        mean_mag;
	logic [2*SAMPLE_BITS-1:0]      mean_sq_full;
	logic [SQR_W-1:0]              variance;

	// Stage 1: register the sample and its square.
	assign mag_in  = sample[SAMPLE_BITS-1] ? -sample : sample;
	assign sq_full = mag_in * mag_in;

	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			smp_s1 <= sample;
			sq_s1  <= sq_full[SQR_W-1:0];
		end
	end

	// Stage 2: accumulate; the ending sample hands the totals to the dividers.
	assign sum_nxt = sum_q + {{(SUM_W-SAMPLE_BITS){smp_s1[SAMPLE_BITS-1]}}, smp_s1};
	assign sqs_nxt = sqs_q + {{(SQ_W-SQR_W){1'b0}}, sq_s1};
	assign sum_mag = sum_nxt[SUM_W-1] ? -sum_nxt : sum_nxt;
	assign div_load = ctrl.acc & ctrl.fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			sqs_q <= '0;
		end else if (ctrl.acc) begin
			sum_q <= ctrl.fin ? '0 : sum_nxt;
			sqs_q <= ctrl.fin ? '0 : sqs_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (div_load) begin
			neg_q <= sum_nxt[SUM_W-1];
		end
	end

	gbnc_div u_div_sum (
		.clk      (clk),
		.load     (div_load),
		.step     (ctrl.div_step),
		.dividend ({{(SQ_W-SUM_W){1'b0}}, sum_mag}),
		.divisor  (count),
		.quotient (q_sum)
	);

	gbnc_div u_div_sqs (
		.clk      (clk),
		.load     (div_load),
		.step     (ctrl.div_step),
		.dividend (sqs_nxt),
		.divisor  (count),
		.quotient (q_sqs)
	);

	// Square of the truncated mean, registered before the subtraction.
	assign mean_mag     = q_sum[SAMPLE_BITS-1:0];
	assign mean_sq_full = mean_mag * mean_mag;

	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			msq_q     <= mean_sq_full[SQR_W-1:0];
			mean_sq_q <= q_sqs[SQR_W-1:0];
		end
	end

	// Variance clamps at zero when truncation makes it negative.
	assign variance = (mean_sq_q > msq_q) ? (mean_sq_q - msq_q) : '0;

	gbnc_isqrt u_isqrt (
		.clk      (clk),
		.load     (ctrl.root_load),
		.step     (ctrl.root_step),
		.radicand (variance),
		.root     (noise)
	);

	// Truncation toward zero: restore the sign on the magnitude quotient.
	assign bias = neg_q ? -mean_mag : mean_mag;

endmodule

@@ rtl/core/gyro_bias_noise_calibration.sv @@
// Gyro bias and noise calibration. Each accepted three-axis sample is squared and
// added to per-axis sums; a sample with last set, or the MAX_SAMPLES-th sample of
// a run, ends the run and yields one result per run: the per-axis mean truncated
// toward zero (bias) and the floor of the square root of the clamped variance
// (noise). All accumulators then restart from zero. A sample that does not end a
// run does not stall the input. The sample that ends a run keeps the input
// stalled after its transfer while it is accumulated, the bit-serial count
// dividers run, the mean is squared, the variance is formed, the bit-serial
// square root runs and the result register is loaded; that load waits while an
// earlier result is still stalled at the output. The three axes run in parallel
// lanes. A finished result waits in the output register while the next run's
// samples are taken.
module gyro_bias_noise_calibration import gbnc_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] gyro_x,
	input  logic signed [SAMPLE_BITS-1:0] gyro_y,
	input  logic signed [SAMPLE_BITS-1:0] gyro_z,
	input  logic                          last,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic signed [SAMPLE_BITS-1:0] bias_x,
	output logic signed [SAMPLE_BITS-1:0] bias_y,
	output logic signed [SAMPLE_BITS-1:0] bias_z,
	output logic [SAMPLE_BITS-1:0]        noise_x,
	output logic [SAMPLE_BITS-1:0]        noise_y,
	output logic [SAMPLE_BITS-1:0]        noise_z
);

`include "gyro_bias_noise_calibration_defines.svh"

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DIV   = 6'b000010,
		ST_MUL   = 6'b000100,
		ST_RLOAD = 6'b001000,
		ST_ROOT  = 6'b010000,
		ST_WRITE = 6'b100000
	} state_t;

	state_t                        state_q;
	state_t                        state_nxt;
	logic [STEP_W-1:0]             step_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [CNT_W-1:0]              cnt_div_q;
	logic                          vld_s1;
	logic                          fin_s1;
	logic                          result_valid_q;
	logic signed [SAMPLE_BITS-1:0] bias_q [AXES];
	logic [SAMPLE_BITS-1:0]        noise_q [AXES];

	logic                          in_take;
	logic                          run_end;
	logic                          out_load;
	lane_ctrl_t                    ctrl;
	logic signed [SAMPLE_BITS-1:0] lane_sample [AXES];
	logic signed [SAMPLE_BITS-1:0] lane_bias [AXES];
	logic [SAMPLE_BITS-1:0]        lane_noise [AXES];

	// Input transfers are taken only while accumulating.
	assign sample_stall = (state_q != ST_IDLE) | (vld_s1 & fin_s1);
	assign in_take      = sample_valid & ~sample_stall;
	assign run_end      = last | (cnt_q == CNT_W'(MAX_SAMPLES - 1));

	// Sample count and stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
			fin_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_take;
			if (in_take) begin
				fin_s1 <= run_end;
				cnt_q  <= run_end ? '0 : cnt_q + 1'b1;
			end
		end
	end

	// The final count is held as the divisor for the whole finishing pass.
	always_ff @(posedge clk) begin
		if (in_take && run_end) begin
			cnt_div_q <= cnt_q + 1'b1;
		end
	end

	// Finishing sequencer.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (vld_s1 && fin_s1) state_nxt = ST_DIV;
			ST_DIV:   if (step_q == STEP_W'(SQ_W - 1)) state_nxt = ST_MUL;
			ST_MUL:   state_nxt = ST_RLOAD;
			ST_RLOAD: state_nxt = ST_ROOT;
			ST_ROOT:  if (step_q == STEP_W'(SAMPLE_BITS - 1)) state_nxt = ST_WRITE;
			ST_WRITE: if (out_load) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_nxt != state_q) begin
				step_q <= '0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Lane commands.
	always_comb begin
		ctrl.take      = in_take;
		ctrl.acc       = vld_s1;
		ctrl.fin       = fin_s1;
		ctrl.div_step  = (state_q == ST_DIV);
		ctrl.mul       = (state_q == ST_MUL);
		ctrl.root_load = (state_q == ST_RLOAD);
		ctrl.root_step = (state_q == ST_ROOT);
	end

	assign lane_sample[0] = gyro_x;
	assign lane_sample[1] = gyro_y;
	assign lane_sample[2] = gyro_z;

	for (genvar a = 0; a < AXES; a++) begin : g_lane
		gbnc_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.sample (lane_sample[a]),
			.count  (cnt_div_q),
			.bias   (lane_bias[a]),
			.noise  (lane_noise[a])
		);
	end

	// Merge the lane results into the output register.
	assign out_load = (state_q == ST_WRITE) & (~result_valid_q | ~result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int a = 0; a < AXES; a++) begin
				bias_q[a]  <= lane_bias[a];
				noise_q[a] <= lane_noise[a];
			end
		end
	end

	assign result_valid = result_valid_q;
	assign bias_x       = bias_q[0];
	assign bias_y       = bias_q[1];
	assign bias_z       = bias_q[2];
	assign noise_x      = noise_q[0];
	assign noise_y      = noise_q[1];
	assign noise_z      = noise_q[2];

	// The running count never reaches the run limit, since that sample ends the run.
	`GBNC_ASSERT_IMP(a_cnt_below_max, 1'b1, cnt_q < CNT_W'(MAX_SAMPLES), "count reached limit")
	// The dividers never run with a zero divisor.
	`GBNC_ASSERT_IMP(a_div_nonzero, state_q == ST_DIV, cnt_div_q != '0, "zero divisor")
	// Only a run-ending sample starts the finishing pass.
	`GBNC_ASSERT_NXT(a_idle_holds, (state_q == ST_IDLE) && !(vld_s1 && fin_s1),
		state_q == ST_IDLE, "finishing pass without run end")
	// A result loaded into the output register is offered in the next cycle.
	`GBNC_ASSERT_NXT(a_load_shows, out_load, result_valid, "loaded result not offered")

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
	import gbnc_pkg::*;

	// One raw three-axis sample and its end-of-run flag.
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] gx;
		logic signed [SAMPLE_BITS-1:0] gy;
		logic signed [SAMPLE_BITS-1:0] gz;
		logic                          fin;
	} gyro_sample_t;

	// One calibration result; index 0 is the x axis.
	typedef struct packed {
		logic [AXES-1:0][SAMPLE_BITS-1:0] bias;
		logic [AXES-1:0][SAMPLE_BITS-1:0] noise;
	} cal_result_t;

	localparam int STYLE_WIDE    = 0;
	localparam int STYLE_CLUSTER = 1;
	localparam int STYLE_EXTREME = 2;

	// Cycles without any transfer before the run is declared hung.
	localparam int QUIET_LIMIT = 3000;
	// Pending samples below which neither side idles any more.
	localparam int CALM_ITEMS  = 120;
	// Cycles to wait after the last expected result has arrived.
	localparam int DRAIN_CYCLES = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic signed [SAMPLE_BITS-1:0] gyro_x = '0;
	logic signed [SAMPLE_BITS-1:0] gyro_y = '0;
	logic signed [SAMPLE_BITS-1:0] gyro_z = '0;
	logic last = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [SAMPLE_BITS-1:0] bias_x, bias_y, bias_z;
	logic [SAMPLE_BITS-1:0] noise_x, noise_y, noise_z;

	logic [AXES-1:0][SAMPLE_BITS-1:0] got_bias, got_noise;
	assign got_bias  = {bias_z, bias_y, bias_x};
	assign got_noise = {noise_z, noise_y, noise_x};

	gyro_sample_t sample_q[$];
	cal_result_t  cal_q[$];

	// Predictor state for the run in progress.
	logic [CNT_W-1:0]        run_count = '0;
	logic signed [SUM_W-1:0] run_sum [AXES] = '{default: '0};
	logic [SQ_W-1:0]         run_sq_sum [AXES] = '{default: '0};

	int error_count = 0;
	int samples_sent = 0;
	int results_checked = 0;
	int limit_runs = 0;
	int send_gap = 0;
	int hold_gap = 0;
	int quiet_cycles = 0;
	string axis_tag [AXES] = '{"x", "y", "z"};

	gyro_bias_noise_calibration u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.gyro_x       (gyro_x),
		.gyro_y       (gyro_y),
		.gyro_z       (gyro_z),
		.last         (last),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.bias_x       (bias_x),
		.bias_y       (bias_y),
		.bias_z       (bias_z),
		.noise_x      (noise_x),
		.noise_y      (noise_y),
		.noise_z      (noise_z)
	);

	always #10 clk = ~clk;

	// Floor of the square root, found one bit at a time from the top.
	function automatic logic [SAMPLE_BITS-1:0] floor_root(longint v);
		longint root;
		longint trial;
		root = 0;
		for (int b = SAMPLE_BITS - 1; b >= 0; b--) begin
			trial = root | (longint'(1) << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root[SAMPLE_BITS-1:0];
	endfunction

	// Adds one accepted sample to the run and closes the run when it ends.
	task automatic fold_sample(gyro_sample_t s);
		logic signed [SAMPLE_BITS-1:0] rate [AXES];
		cal_result_t want;
		longint mean;
		longint mean_sq;
		longint quot;
		longint spread;
		rate[0] = s.gx;
		rate[1] = s.gy;
		rate[2] = s.gz;
		for (int a = 0; a < AXES; a++) begin
			run_sum[a] = run_sum[a] + rate[a];
			run_sq_sum[a] = run_sq_sum[a] + SQ_W'(longint'(rate[a]) * longint'(rate[a]));
		end
		run_count = run_count + 1'b1;
		if (s.fin || run_count == MAX_SAMPLES) begin
			if (!s.fin)
				limit_runs++;
			for (int a = 0; a < AXES; a++) begin
				mean = longint'(run_sum[a]) / longint'(run_count);
				mean_sq = mean * mean;
				quot = longint'(run_sq_sum[a]) / longint'(run_count);
				spread = (quot > mean_sq) ? quot - mean_sq : 0;
				want.bias[a] = mean[SAMPLE_BITS-1:0];
				want.noise[a] = floor_root(spread);
			end
			cal_q.push_back(want);
			run_count = '0;
			for (int a = 0; a < AXES; a++) begin
				run_sum[a] = '0;
				run_sq_sum[a] = '0;
			end
		end
	endtask

	task automatic add_sample(int x, int y, int z, bit fin);
		gyro_sample_t s;
		s.gx = x[SAMPLE_BITS-1:0];
		s.gy = y[SAMPLE_BITS-1:0];
		s.gz = z[SAMPLE_BITS-1:0];
		s.fin = fin;
		sample_q.push_back(s);
	endtask

	// One random rate value in the given style.
	function automatic int rand_rate(int style, int center, int width);
		int v;
		int picks [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
		case (style)
			STYLE_CLUSTER: begin
				v = center + int'($urandom_range(0, 2 * width)) - width;
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
			end
			STYLE_EXTREME: begin
				v = picks[$urandom_range(0, 6)];
			end
			default: begin
				v = int'($urandom_range(0, 65535)) - 32768;
			end
		endcase
		return v;
	endfunction

	// Queues a run of samples; the last one carries the end flag if asked.
	task automatic push_run(int len, bit close, int style);
		int center [AXES];
		int width;
		for (int a = 0; a < AXES; a++)
			center[a] = int'($urandom_range(0, 64000)) - 32000;
		width = 1 << $urandom_range(0, 11);
		for (int i = 0; i < len; i++)
			add_sample(rand_rate(style, center[0], width), rand_rate(style, center[1], width),
				rand_rate(style, center[2], width), close && (i == len - 1));
	endtask

	// Driver: presents queued samples and holds each one until its transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (sample_valid && !sample_stall) begin
				fold_sample({gyro_x, gyro_y, gyro_z, last});
				samples_sent++;
			end
			if (!sample_valid || !sample_stall) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					sample_valid <= 1'b0;
				end else if (sample_q.size() >= CALM_ITEMS && $urandom_range(0, 7) == 0) begin
					send_gap <= $urandom_range(0, 18);
					sample_valid <= 1'b0;
				end else if (sample_q.size() != 0) begin
					{gyro_x, gyro_y, gyro_z, last} <= sample_q.pop_front();
					sample_valid <= 1'b1;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result transfer and stalls the output at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_gap <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (cal_q.size() == 0) begin
					$error("unexpected result: bias %0d %0d %0d, noise %0d %0d %0d",
						bias_x, bias_y, bias_z, noise_x, noise_y, noise_z);
					error_count++;
				end else begin
					cal_result_t want;
					want = cal_q.pop_front();
					results_checked++;
					for (int a = 0; a < AXES; a++) begin
						if (want.bias[a] !== got_bias[a]) begin
							$error("bias_%s: expected %0d, got %0d", axis_tag[a],
								$signed(want.bias[a]), $signed(got_bias[a]));
							error_count++;
						end
						if (want.noise[a] !== got_noise[a]) begin
							$error("noise_%s: expected %0d, got %0d", axis_tag[a],
								want.noise[a], got_noise[a]);
							error_count++;
						end
					end
				end
			end
			if (hold_gap != 0) begin
				hold_gap <= hold_gap - 1;
				result_stall <= 1'b1;
			end else if (sample_q.size() >= CALM_ITEMS && $urandom_range(0, 7) == 0) begin
				hold_gap <= $urandom_range(0, 18);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Watchdog: ends the run if no transfer happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout after %0d cycles without a transfer", quiet_cycles);
				$display("testbench: errors");
				$finish;
			end
		end
	end

	initial begin
		int run_idx;

		// Directed runs: single-sample runs at both extremes.
		add_sample(32767, -32768, 0, 1'b1);
		add_sample(-32768, 32767, -1, 1'b1);
		// Widest possible spread on x, constant extreme on y.
		add_sample(32767, -32768, 0, 1'b0);
		add_sample(-32768, -32768, -1, 1'b0);
		add_sample(32767, -32768, 0, 1'b0);
		add_sample(-32768, -32768, -1, 1'b1);
		// Odd sums, so the mean truncates toward zero on both signs.
		add_sample(-3, 3, -7, 1'b0);
		add_sample(-4, 4, -8, 1'b1);
		// Constant input gives zero noise.
		add_sample(100, -100, 7, 1'b0);
		add_sample(100, -100, 7, 1'b0);
		add_sample(100, -100, 7, 1'b1);
		// Small spread where both truncations bite.
		add_sample(1, -1, 0, 1'b0);
		add_sample(2, -2, 1, 1'b0);
		add_sample(2, -1, 1, 1'b0);
		add_sample(-5, 6, 1, 1'b1);

		// Random runs, with two runs that reach the sample limit.
		run_idx = 0;
		while (sample_q.size() < 975) begin
			if (run_idx == 4)
				push_run(MAX_SAMPLES, 1'b0, STYLE_CLUSTER);
			else if (run_idx == 30)
				push_run(MAX_SAMPLES, 1'b1, STYLE_WIDE);
			else
				push_run($urandom_range(1, 16), $urandom_range(0, 9) != 0,
					$urandom_range(STYLE_WIDE, STYLE_EXTREME));
			run_idx++;
		end
		push_run(1, 1'b1, STYLE_EXTREME);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (sample_q.size() != 0 || sample_valid || cal_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d samples sent, %0d calibration results checked field by field",
			samples_sent, results_checked);
		$display("%0d runs were closed by the sample limit rather than the end flag", limit_runs);
		if (error_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
